### src/rbmgs_pkg.sv
// Shared types and constants of the Gibbs node sampler.
`default_nettype none
package rbmgs_pkg;

    // Command codes of the input item.
    localparam logic [2:0] CMD_WRITE_WEIGHT = 3'd0;
    localparam logic [2:0] CMD_WRITE_BIAS   = 3'd1;
    localparam logic [2:0] CMD_SET_BIT      = 3'd2;
    localparam logic [2:0] CMD_SAMPLE       = 3'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_VISIBLE_COUNT = 2'd0;
    localparam logic [1:0] CFG_HIDDEN_COUNT  = 2'd1;
    localparam logic [1:0] CFG_INV_TEMP      = 2'd2;

    localparam logic [8:0]  COUNT_RESET    = 9'd256;
    localparam logic [15:0] INV_TEMP_RESET = 16'd256;

    localparam int ENERGY_W = 25;
    localparam int PROB_W   = 16;

    // Work classes that the front end hands to the back end.
    typedef enum logic [2:0] {
        OP_WEIGHT,
        OP_BIAS,
        OP_BIT,
        OP_SAMPLE,
        OP_REJECT
    } op_t;

    typedef struct packed {
        op_t                op;
        logic               is_hid;
        logic [8:0]         own_idx;
        logic [9:0]         opp_count;
        logic [7:0]         vis_index;
        logic [7:0]         hid_index;
        logic signed [15:0] value;
        logic               bit_value;
        logic [15:0]        random_value;
    } work_t;

endpackage
`default_nettype wire

### src/rbmgs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rbmgs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

### src/rbmgs_front.sv
// Front end: decodes and range-checks commands into a two-entry work queue.
`default_nettype none
module rbmgs_front #(
    parameter int MAX_VISIBLE = 256,
    parameter int MAX_HIDDEN  = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [2:0]         cmd,
    input  wire logic [8:0]         node_index,
    input  wire logic [7:0]         vis_index,
    input  wire logic [7:0]         hid_index,
    input  wire logic signed [15:0] value,
    input  wire logic               bit_value,
    input  wire logic [15:0]        random_value,
    input  wire logic [8:0]         visible_count,
    input  wire logic [8:0]         hidden_count,
    output logic                    q_valid,
    output rbmgs_pkg::work_t        q_item,
    input  wire logic               q_pop
);

    rbmgs_pkg::work_t entry_reg [2];
    rbmgs_pkg::work_t item;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic [8:0] nv, nh, vnode;
    logic [9:0] total;
    logic       is_hid, in_range, weight_ok, keep, store;

    always_comb
    begin
        nv = ({4'b0, visible_count} < 13'(MAX_VISIBLE)) ? visible_count : 9'(MAX_VISIBLE);
        nh = ({4'b0, hidden_count} < 13'(MAX_HIDDEN)) ? hidden_count : 9'(MAX_HIDDEN);
        total = {1'b0, nh} + {1'b0, nv};
        is_hid = node_index < nh;
        in_range = {1'b0, node_index} < total;
        vnode = node_index - nh;
        weight_ok = ({5'b0, vis_index} < 13'(MAX_VISIBLE))
                    && ({5'b0, hid_index} < 13'(MAX_HIDDEN));

        item.is_hid = is_hid;
        item.own_idx = is_hid ? node_index : vnode;
        item.opp_count = is_hid ? {1'b0, nv} : {1'b0, nh};
        item.vis_index = vis_index;
        item.hid_index = hid_index;
        item.value = value;
        item.bit_value = bit_value;
        item.random_value = random_value;
        item.op = rbmgs_pkg::OP_REJECT;
        keep = 1'b0;
        unique case (cmd)
            rbmgs_pkg::CMD_WRITE_WEIGHT:
            begin
                item.op = rbmgs_pkg::OP_WEIGHT;
                keep = weight_ok;
            end
            rbmgs_pkg::CMD_WRITE_BIAS:
            begin
                item.op = rbmgs_pkg::OP_BIAS;
                keep = in_range;
            end
            rbmgs_pkg::CMD_SET_BIT:
            begin
                item.op = rbmgs_pkg::OP_BIT;
                keep = in_range;
            end
            rbmgs_pkg::CMD_SAMPLE:
            begin
                item.op = in_range ? rbmgs_pkg::OP_SAMPLE : rbmgs_pkg::OP_REJECT;
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign full = (count_reg == 2'd2);
    assign store = push && !full && keep;
    assign q_valid = (count_reg != 2'd0);
    assign q_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ store;
        rd_ptr_next = rd_ptr_reg ^ (q_pop && q_valid);
        count_next = count_reg + {1'b0, store} - {1'b0, q_pop && q_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            entry_reg[wr_ptr_reg] <= item;
        end
    end

endmodule
`default_nettype wire

### src/rbmgs_back.sv
// Back end: executes stores, accumulates the energy and draws the new bit.
`default_nettype none
module rbmgs_back #(
    parameter int MAX_VISIBLE     = 256,
    parameter int MAX_HIDDEN      = 256,
    parameter int SIGMOID_ENTRIES = 1024,
    parameter int WEIGHT_BITS     = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_valid,
    input  wire rbmgs_pkg::work_t            q_item,
    output logic                             q_pop,
    input  wire logic [15:0]                 inv_temperature,
    input  wire logic                        pop,
    output logic                             empty,
    output logic                             sampled_bit,
    output logic [rbmgs_pkg::PROB_W-1:0]     probability,
    output logic signed [rbmgs_pkg::ENERGY_W-1:0] energy_diff,
    output logic                             status
);

    localparam int VIS_W   = $clog2(MAX_VISIBLE);
    localparam int HID_W   = $clog2(MAX_HIDDEN);
    localparam int WADDR_W = $clog2(MAX_VISIBLE * MAX_HIDDEN);
    localparam int TAB_W   = $clog2(SIGMOID_ENTRIES);
    localparam int ACC_W   = (WEIGHT_BITS + 11 > 27) ? WEIGHT_BITS + 11 : 27;
    localparam logic signed [32:0] W_HI = (33'sd1 <<< (WEIGHT_BITS - 1)) - 33'sd1;
    localparam logic signed [32:0] W_LO = -W_HI - 33'sd1;
    localparam logic signed [ACC_W-1:0] EN_MAX = ACC_W'((64'sd1 <<< 24) - 64'sd1);
    localparam logic signed [ACC_W-1:0] EN_MIN = ACC_W'(-(64'sd1 <<< 24));
    localparam logic signed [41:0] S_MAX = 42'sd8388607;
    localparam logic signed [41:0] S_MIN = -42'sd8388608;

    typedef logic [15:0] sig_tab_t [SIGMOID_ENTRIES];

    // Shift-and-subtract division, only evaluated while building the table.
    function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] quo, rem;
        int          b;
        quo = '0;
        rem = '0;
        for (b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], n[b]};
            if (rem >= d)
            begin
                rem = rem - d;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // p = 1/(1+exp(x)) at the low edge of each table step, built at elaboration.
    function automatic sig_tab_t build_sig_table();
        sig_tab_t    tab;
        logic [63:0] q, a, y, term, sum, den, num, p;
        logic        nonneg;
        int          k, i, sq;
        for (k = 0; k < SIGMOID_ENTRIES; k++)
        begin
            q = div_u64(64'(k) << 24, 64'(SIGMOID_ENTRIES));
            nonneg = (q >= 64'd8388608);
            a = nonneg ? q - 64'd8388608 : 64'd8388608 - q;
            y = a << 7;
            term = 64'd2147483648;
            sum = 64'd2147483648;
            for (i = 1; i <= 20; i++)
            begin
                term = div_u64((term * y) >> 31, 64'(i));
                if ((i & 1) == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            for (sq = 0; sq < 4; sq++)
            begin
                sum = (sum * sum) >> 31;
            end
            den = 64'd2147483648 + sum;
            num = nonneg ? sum : 64'd2147483648;
            p = div_u64(num * 64'd65536 + (den >> 1), den);
            tab[k] = (p > 64'd65535) ? 16'hFFFF : p[15:0];
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG_TABLE = build_sig_table();

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_DRAIN,
        S_SCALE,
        S_LOOK,
        S_FETCH,
        S_DONE
    } state_t;

    state_t state_reg;
    logic [MAX_VISIBLE-1:0] vis_bits_reg;
    logic [MAX_HIDDEN-1:0]  hid_bits_reg;
    logic                   is_hid_reg;
    logic [8:0]             own_idx_reg;
    logic [9:0]             count_reg;
    logic [9:0]             cnt_reg;
    logic [15:0]            rnd_reg;
    logic                   rd_valid_reg;
    logic                   rd_bit_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [rbmgs_pkg::ENERGY_W-1:0] energy_reg;
    logic signed [41:0]     prod_reg;
    logic [TAB_W-1:0]       k_reg;
    logic [15:0]            p_reg;
    logic                   out_valid_reg;
    logic                   out_bit_reg;
    logic [15:0]            out_prob_reg;
    logic signed [rbmgs_pkg::ENERGY_W-1:0] out_energy_reg;
    logic                   out_status_reg;

    logic                   take, issue, opp_bit, new_bit;
    logic [WADDR_W-1:0]     w_wr_addr, w_rd_addr, own_ext, cnt_ext;
    logic signed [32:0]     w_clamp;
    logic [WEIGHT_BITS-1:0] w_rdata;
    logic [15:0]            hb_rdata, vb_rdata;
    logic signed [ACC_W-1:0] w_ext, bias_ext, total;
    logic signed [41:0]     s_clamp;
    logic [23:0]            s_off;
    logic [24+TAB_W+1:0]    k_wide;

    // A sample may start only when the result slot is free.
    always_comb
    begin
        take = 1'b0;
        if (state_reg == S_IDLE && q_valid)
        begin
            if (q_item.op == rbmgs_pkg::OP_SAMPLE || q_item.op == rbmgs_pkg::OP_REJECT)
                take = !out_valid_reg;
            else
                take = 1'b1;
        end
    end
    assign q_pop = take;

    always_comb
    begin
        w_clamp = 33'($signed(q_item.value));
        if (w_clamp > W_HI)
            w_clamp = W_HI;
        else if (w_clamp < W_LO)
            w_clamp = W_LO;
        w_wr_addr = WADDR_W'(WADDR_W'(q_item.vis_index) * WADDR_W'(MAX_HIDDEN)
                    + WADDR_W'(q_item.hid_index));
        own_ext = WADDR_W'(own_idx_reg);
        cnt_ext = WADDR_W'(cnt_reg);
        w_rd_addr = is_hid_reg ? WADDR_W'(cnt_ext * WADDR_W'(MAX_HIDDEN) + own_ext)
                               : WADDR_W'(own_ext * WADDR_W'(MAX_HIDDEN) + cnt_ext);
        issue = (state_reg == S_ACC) && (cnt_reg < count_reg);
        opp_bit = is_hid_reg ? vis_bits_reg[VIS_W'(cnt_reg)] : hid_bits_reg[HID_W'(cnt_reg)];
        w_ext = ACC_W'($signed(w_rdata));
        bias_ext = ACC_W'($signed(is_hid_reg ? hb_rdata : vb_rdata));
        total = acc_reg - bias_ext;
        s_clamp = prod_reg;
        if (s_clamp > S_MAX)
            s_clamp = S_MAX;
        else if (s_clamp < S_MIN)
            s_clamp = S_MIN;
        s_off = 24'(s_clamp + 42'sd8388608);
        k_wide = (24+TAB_W+2)'(s_off) * (24+TAB_W+2)'(SIGMOID_ENTRIES);
        new_bit = rnd_reg < p_reg;
    end

    rbmgs_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_VISIBLE * MAX_HIDDEN)) u_weight_ram (
        .clk     (clk),
        .wr_en   (take && q_item.op == rbmgs_pkg::OP_WEIGHT),
        .wr_addr (w_wr_addr),
        .wr_data (WEIGHT_BITS'(w_clamp)),
        .rd_addr (w_rd_addr),
        .rd_data (w_rdata)
    );

    rbmgs_ram #(.WIDTH(16), .DEPTH(MAX_HIDDEN)) u_hid_bias_ram (
        .clk     (clk),
        .wr_en   (take && q_item.op == rbmgs_pkg::OP_BIAS && q_item.is_hid),
        .wr_addr (HID_W'(q_item.own_idx)),
        .wr_data (q_item.value),
        .rd_addr (HID_W'(own_idx_reg)),
        .rd_data (hb_rdata)
    );

    rbmgs_ram #(.WIDTH(16), .DEPTH(MAX_VISIBLE)) u_vis_bias_ram (
        .clk     (clk),
        .wr_en   (take && q_item.op == rbmgs_pkg::OP_BIAS && !q_item.is_hid),
        .wr_addr (VIS_W'(q_item.own_idx)),
        .wr_data (q_item.value),
        .rd_addr (VIS_W'(own_idx_reg)),
        .rd_data (vb_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vis_bits_reg <= '0;
            hid_bits_reg <= '0;
            is_hid_reg <= 1'b0;
            own_idx_reg <= '0;
            count_reg <= '0;
            cnt_reg <= '0;
            rnd_reg <= '0;
            rd_valid_reg <= 1'b0;
            rd_bit_reg <= 1'b0;
            acc_reg <= '0;
            energy_reg <= '0;
            prod_reg <= '0;
            k_reg <= '0;
            p_reg <= '0;
            out_valid_reg <= 1'b0;
            out_bit_reg <= 1'b0;
            out_prob_reg <= '0;
            out_energy_reg <= '0;
            out_status_reg <= 1'b0;
        end
        else
        begin
            if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        unique case (q_item.op)
                            rbmgs_pkg::OP_BIT:
                            begin
                                if (q_item.is_hid)
                                    hid_bits_reg[HID_W'(q_item.own_idx)] <= q_item.bit_value;
                                else
                                    vis_bits_reg[VIS_W'(q_item.own_idx)] <= q_item.bit_value;
                            end
                            rbmgs_pkg::OP_REJECT:
                            begin
                                out_valid_reg <= 1'b1;
                                out_bit_reg <= 1'b0;
                                out_prob_reg <= '0;
                                out_energy_reg <= '0;
                                out_status_reg <= 1'b1;
                            end
                            rbmgs_pkg::OP_SAMPLE:
                            begin
                                is_hid_reg <= q_item.is_hid;
                                own_idx_reg <= q_item.own_idx;
                                count_reg <= q_item.opp_count;
                                rnd_reg <= q_item.random_value;
                                cnt_reg <= '0;
                                acc_reg <= '0;
                                rd_valid_reg <= 1'b0;
                                state_reg <= S_ACC;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_ACC:
                begin
                    // One weight read per cycle; its data is added in the next cycle.
                    if (rd_valid_reg && rd_bit_reg)
                        acc_reg <= acc_reg - w_ext;
                    rd_valid_reg <= issue;
                    rd_bit_reg <= opp_bit;
                    if (issue)
                        cnt_reg <= cnt_reg + 10'd1;
                    else
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    if (total > EN_MAX)
                        energy_reg <= EN_MAX[rbmgs_pkg::ENERGY_W-1:0];
                    else if (total < EN_MIN)
                        energy_reg <= EN_MIN[rbmgs_pkg::ENERGY_W-1:0];
                    else
                        energy_reg <= total[rbmgs_pkg::ENERGY_W-1:0];
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    prod_reg <= 42'(energy_reg) * 42'($signed({1'b0, inv_temperature}));
                    state_reg <= S_LOOK;
                end
                S_LOOK:
                begin
                    k_reg <= TAB_W'(k_wide >> 24);
                    state_reg <= S_FETCH;
                end
                S_FETCH:
                begin
                    p_reg <= SIG_TABLE[k_reg];
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (is_hid_reg)
                        hid_bits_reg[HID_W'(own_idx_reg)] <= new_bit;
                    else
                        vis_bits_reg[VIS_W'(own_idx_reg)] <= new_bit;
                    out_valid_reg <= 1'b1;
                    out_bit_reg <= new_bit;
                    out_prob_reg <= p_reg;
                    out_energy_reg <= energy_reg;
                    out_status_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign empty = !out_valid_reg;
    assign sampled_bit = out_bit_reg;
    assign probability = out_prob_reg;
    assign energy_diff = out_energy_reg;
    assign status = out_status_reg;

endmodule
`default_nettype wire

### src/rbm_gibbs_node_sampler_unit.sv
// Store writes are done in the back end as they leave the work queue.
// A sample adds one weight per cycle over the opposite-layer nodes, through the
// weight memory's single read port. An out-of-range sample only returns status set.
// A two-entry queue lets new commands in while a sample or a result waits.
// Reset clears all unit bits and sets the counts and inverse temperature to 256;
// weight and bias memories hold nothing until written.
`default_nettype none
module rbm_gibbs_node_sampler_unit #(
    parameter int MAX_VISIBLE     = 256,
    parameter int MAX_HIDDEN      = 256,
    parameter int SIGMOID_ENTRIES = 1024,
    parameter int WEIGHT_BITS     = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [2:0]         cmd,
    input  wire logic [8:0]         node_index,
    input  wire logic [7:0]         vis_index,
    input  wire logic [7:0]         hid_index,
    input  wire logic signed [15:0] value,
    input  wire logic               bit_value,
    input  wire logic [15:0]        random_value,
    output logic                    empty,
    input  wire logic               pop,
    output logic                    sampled_bit,
    output logic [15:0]             probability,
    output logic signed [24:0]      energy_diff,
    output logic                    status,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    logic [8:0]       visible_count_reg;
    logic [8:0]       hidden_count_reg;
    logic [15:0]      inv_temp_reg;
    logic             q_valid, q_pop;
    rbmgs_pkg::work_t q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visible_count_reg <= rbmgs_pkg::COUNT_RESET;
            hidden_count_reg <= rbmgs_pkg::COUNT_RESET;
            inv_temp_reg <= rbmgs_pkg::INV_TEMP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rbmgs_pkg::CFG_VISIBLE_COUNT: visible_count_reg <= cfg_data[8:0];
                rbmgs_pkg::CFG_HIDDEN_COUNT:  hidden_count_reg <= cfg_data[8:0];
                rbmgs_pkg::CFG_INV_TEMP:      inv_temp_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    rbmgs_front #(
        .MAX_VISIBLE (MAX_VISIBLE),
        .MAX_HIDDEN  (MAX_HIDDEN)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .cmd           (cmd),
        .node_index    (node_index),
        .vis_index     (vis_index),
        .hid_index     (hid_index),
        .value         (value),
        .bit_value     (bit_value),
        .random_value  (random_value),
        .visible_count (visible_count_reg),
        .hidden_count  (hidden_count_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    rbmgs_back #(
        .MAX_VISIBLE     (MAX_VISIBLE),
        .MAX_HIDDEN      (MAX_HIDDEN),
        .SIGMOID_ENTRIES (SIGMOID_ENTRIES),
        .WEIGHT_BITS     (WEIGHT_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .inv_temperature (inv_temp_reg),
        .pop             (pop),
        .empty           (empty),
        .sampled_bit     (sampled_bit),
        .probability     (probability),
        .energy_diff     (energy_diff),
        .status          (status)
    );

endmodule
`default_nettype wire
